@@ hw/rtl/u2tf_pkg.sv @@
`timescale 1ns / 1ps
package u2tf_pkg;

	localparam int CHUNK_W = 64;
	localparam int CHARS_W = 4;
	localparam int FMT_W   = 2;

	// format selector bits; format three falls on binary
	localparam int FMT_DEC_BIT = 0;
	localparam int FMT_BIN_BIT = 1;

	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_X        = 8'h78;
	localparam logic [7:0] CH_B        = 8'h62;
	localparam logic [7:0] CH_HEX_BASE = 8'h57;  // 'a' - 10

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CONV   = 5'b00010,
		ST_PRE0   = 5'b00100,
		ST_PRE1   = 5'b01000,
		ST_DIGITS = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic digit_step;
		logic is_bin;
		logic is_dec;
	} shift_ctrl_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'b0000, d};
		end else begin
			c = CH_HEX_BASE + {4'b0000, d};
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/u2tf_shift_unit.sv @@
`timescale 1ns / 1ps
module u2tf_shift_unit #(
	parameter int VALUE_BITS     = 128,
	parameter int DECIMAL_DIGITS = 40
) (
	input  logic                     clk,
	input  u2tf_pkg::shift_ctrl_t    ctrl,
	input  logic [VALUE_BITS-1:0]    load_value,
	output logic [3:0]               digit
);
	import u2tf_pkg::*;

	localparam int HEX_W = ((VALUE_BITS + 3) / 4) * 4;
	localparam int BCD_W = DECIMAL_DIGITS * 4;

	logic [HEX_W-1:0] val_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] bcd_adj;

	// add-3 on every digit of 5 or more, then one shift doubles the register
	always_comb begin
		for (int g = 0; g < DECIMAL_DIGITS; g++) begin
			if (bcd_q[4*g +: 4] >= 4'd5) begin
				bcd_adj[4*g +: 4] = bcd_q[4*g +: 4] + 4'd3;
			end else begin
				bcd_adj[4*g +: 4] = bcd_q[4*g +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= HEX_W'(load_value);
			bcd_q <= '0;
		end else if (ctrl.conv_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], val_q[VALUE_BITS-1]};
			val_q <= val_q << 1;
		end else if (ctrl.digit_step) begin
			if (ctrl.is_dec) begin
				bcd_q <= bcd_q << 4;
			end else if (ctrl.is_bin) begin
				val_q <= val_q << 1;
			end else begin
				val_q <= val_q << 4;
			end
		end
	end

	always_comb begin
		if (ctrl.is_dec) begin
			digit = bcd_q[BCD_W-1 -: 4];
		end else if (ctrl.is_bin) begin
			digit = {3'b000, val_q[VALUE_BITS-1]};
		end else begin
			digit = val_q[HEX_W-1 -: 4];
		end
	end

endmodule

@@ hw/rtl/uint128_to_text_formatter_unit.sv @@
`timescale 1ns / 1ps
// Hex and binary items pass ST_PRE0, ST_PRE1 and ST_DIGITS; decimal items pass ST_CONV
// and then ST_DIGITS. One digit per cycle through the digit shift register, unless the
// output stalls, sets the text phase; the decimal conversion is one double-dabble step
// per cycle. One item at a time: the next item is taken the cycle after the last
// digit. arst_n clears the sequencer, chunk packer and output valid; data registers
// are not reset.
module uint128_to_text_formatter_unit #(
	parameter int VALUE_BITS       = 128,
	parameter int DECIMAL_DIGITS   = 40,
	parameter int CHARS_PER_RESULT = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // value_high[63:0], value_low[127:64]
	input  logic [1:0]   s_axis_tuser,  // format[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,  // text_chunk[63:0], chunk_chars[67:64], zero
	output logic         m_axis_tlast   // last_chunk
);
	import u2tf_pkg::*;

	localparam int NIBBLES = (VALUE_BITS + 3) / 4;
	localparam int CNT_MAX = (VALUE_BITS > DECIMAL_DIGITS) ? VALUE_BITS : DECIMAL_DIGITS;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               lead_q;
	logic               is_bin_q;
	logic               is_dec_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [CHARS_W-1:0] fill_q;
	logic               out_valid_q;
	logic [CHUNK_W-1:0] out_data_q;
	logic [CHARS_W-1:0] out_chars_q;
	logic               out_last_q;

	logic               accept;
	logic               out_free;
	logic               emit;
	logic               emit_last;
	logic [7:0]         emit_char;
	logic [CHUNK_W-1:0] chunk_new;
	logic [CHARS_W-1:0] fill_new;
	logic               flush;
	logic               go;
	logic [3:0]         digit;
	logic [127:0]       value_full;
	shift_ctrl_t        sctrl;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign value_full    = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign out_free      = !out_valid_q || m_axis_tready;

	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_char = CH_ZERO;
		case (state_q)
			ST_PRE0: begin
				emit = 1'b1;
			end
			ST_PRE1: begin
				emit      = 1'b1;
				emit_char = is_bin_q ? CH_B : CH_X;
			end
			ST_DIGITS: begin
				// leading zeros are dropped, but the final digit always goes out
				emit      = !(lead_q && (digit == 4'd0) && (cnt_q != CNT_W'(1)));
				emit_last = (cnt_q == CNT_W'(1));
				emit_char = digit_char(digit);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_comb begin
		chunk_new = chunk_q;
		for (int b = 0; b < 8; b++) begin
			if (fill_q == CHARS_W'(b)) begin
				chunk_new[CHUNK_W-1-8*b -: 8] = emit_char;
			end
		end
		fill_new = fill_q + CHARS_W'(1);
		flush    = emit && ((fill_new == CHARS_W'(CHARS_PER_RESULT)) || emit_last);
		go       = !flush || out_free;
	end

	assign sctrl.load       = accept;
	assign sctrl.conv_step  = (state_q == ST_CONV);
	assign sctrl.digit_step = (state_q == ST_DIGITS) && go;
	assign sctrl.is_bin     = is_bin_q;
	assign sctrl.is_dec     = is_dec_q;

	u2tf_shift_unit #(
		.VALUE_BITS    (VALUE_BITS),
		.DECIMAL_DIGITS(DECIMAL_DIGITS)
	) u_shift (
		.clk       (clk),
		.ctrl      (sctrl),
		.load_value(value_full[VALUE_BITS-1:0]),
		.digit     (digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lead_q      <= 1'b0;
			is_bin_q    <= 1'b0;
			is_dec_q    <= 1'b0;
			chunk_q     <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit && go && flush) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit && go) begin
				if (flush) begin
					chunk_q <= '0;
					fill_q  <= '0;
				end else begin
					chunk_q <= chunk_new;
					fill_q  <= fill_new;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						is_bin_q <= s_axis_tuser[FMT_BIN_BIT];
						is_dec_q <= !s_axis_tuser[FMT_BIN_BIT] && s_axis_tuser[FMT_DEC_BIT];
						lead_q   <= 1'b1;
						if (s_axis_tuser[FMT_BIN_BIT]) begin
							cnt_q   <= CNT_W'(VALUE_BITS);
							state_q <= ST_PRE0;
						end else if (s_axis_tuser[FMT_DEC_BIT]) begin
							cnt_q   <= CNT_W'(VALUE_BITS);
							state_q <= ST_CONV;
						end else begin
							cnt_q   <= CNT_W'(NIBBLES);
							state_q <= ST_PRE0;
						end
					end
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(1)) begin
						cnt_q   <= CNT_W'(DECIMAL_DIGITS);
						state_q <= ST_DIGITS;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_PRE0: begin
					if (go) begin
						state_q <= ST_PRE1;
					end
				end
				ST_PRE1: begin
					if (go) begin
						state_q <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (go) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (emit) begin
							lead_q <= 1'b0;
						end
						if (cnt_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit && go && flush) begin
			out_data_q  <= chunk_new;
			out_chars_q <= fill_new;
			out_last_q  <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_chars_q, out_data_q};
	assign m_axis_tlast  = out_last_q;

	a_chars_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_chars_q != '0) && (out_chars_q <= CHARS_W'(CHARS_PER_RESULT)))
		else $error("output word with bad character count");

	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (out_chars_q == CHARS_W'(CHARS_PER_RESULT)))
		else $error("short word before last word");

	a_packer_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (fill_q == '0) && (chunk_q == '0))
		else $error("chunk packer not empty at new item");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (cnt_q != '0))
		else $error("digit counter ran out");

endmodule

@@ bench/tb_uint128_to_text_formatter_unit.sv @@
`timescale 1ns / 1ps
module tb_uint128_to_text_formatter_unit;
	import u2tf_pkg::*;

	typedef enum logic [1:0] {
		FMT_HEX  = 2'd0,
		FMT_DEC  = 2'd1,
		FMT_BIN  = 2'd2,
		FMT_BIN3 = 2'd3
	} fmt_e;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		fmt_e        fmt;
	} request_t;

	typedef struct packed {
		logic [63:0] text;
		logic [3:0]  nchars;
		logic        last;
	} text_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;  // value_high[63:0], value_low[127:64]
	logic [1:0]   s_axis_tuser = '0;  // format[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;       // text_chunk[63:0], chunk_chars[67:64], zero
	logic         m_axis_tlast;       // last_chunk

	request_t   value_queue[$];
	text_word_t expected_words[$];
	int         mismatches = 0;
	int         words_seen = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	bit         calm = 1'b0;

	uint128_to_text_formatter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Builds the text for one value and queues its words.
	function automatic void predict_text(input request_t req);
		logic [127:0] v;
		logic [127:0] q;
		logic [7:0]   txt[$];
		logic [7:0]   digs[$];
		logic [3:0]   nib;
		logic [63:0]  word;
		text_word_t   w;
		int           first;
		int           nwords;
		int           cnt;
		v = {req.hi, req.lo};
		if (req.fmt[FMT_BIN_BIT]) begin
			txt = '{CH_ZERO, CH_B};
			for (int i = 127; i >= 0; i--) begin
				digs.push_back(CH_ZERO + 8'(v[i]));
			end
		end else if (req.fmt[FMT_DEC_BIT]) begin
			q = v;
			for (int j = 0; j < 40; j++) begin
				digs.push_front(CH_ZERO + 8'(q % 128'd10));
				q = q / 128'd10;
			end
		end else begin
			txt = '{CH_ZERO, CH_X};
			for (int i = 31; i >= 0; i--) begin
				nib = v[4 * i +: 4];
				digs.push_back(nib < 4'd10 ? CH_ZERO + 8'(nib) : 8'h61 + 8'(nib - 4'd10));
			end
		end
		// leading zeros go, but one digit always stays
		first = 0;
		while (first < digs.size() - 1 && digs[first] == CH_ZERO) begin
			first++;
		end
		for (int i = first; i < digs.size(); i++) begin
			txt.push_back(digs[i]);
		end
		nwords = (txt.size() + 7) / 8;
		for (int k = 0; k < nwords; k++) begin
			cnt = txt.size() - 8 * k;
			if (cnt > 8) begin
				cnt = 8;
			end
			word = '0;
			for (int i = 0; i < cnt; i++) begin
				word |= 64'(txt[8 * k + i]) << (56 - 8 * i);
			end
			w.text = word;
			w.nchars = 4'(cnt);
			w.last = (k == nwords - 1);
			expected_words.push_back(w);
		end
	endfunction

	task automatic add_value(input logic [127:0] v, input fmt_e f);
		request_t req;
		req.hi = v[127:64];
		req.lo = v[63:0];
		req.fmt = f;
		value_queue.push_back(req);
	endtask

	// sender
	always @(posedge clk) begin : drive
		logic     nxt_valid;
		request_t req;
		int       gap_left;
		nxt_valid = s_axis_tvalid;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_text(value_queue.pop_front());
				nxt_valid = 1'b0;
			end
			if (value_queue.size() < 40) begin
				calm = 1'b1;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (value_queue.size() > 0) begin
					if (!calm && hold_left == 0 && $urandom_range(0, 9) == 0) begin
						gap_left = $urandom_range(0, 7);
					end else begin
						req = value_queue[0];
						nxt_valid = 1'b1;
						s_axis_tdata <= {req.lo, req.hi};
						s_axis_tuser <= req.fmt;
					end
				end
			end
		end else begin
			gap_left = 0;
		end
		s_axis_tvalid <= nxt_valid;
	end

	// receiver and word checker
	always @(posedge clk) begin : watch
		logic       nxt_ready;
		text_word_t w;
		int         stall_left;
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					$error("unexpected word: text %h chars %0d last %0b",
						m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast);
					mismatches++;
				end else begin
					w = expected_words.pop_front();
					if (m_axis_tdata[63:0] !== w.text) begin
						$error("text_chunk: expected %h, got %h", w.text, m_axis_tdata[63:0]);
						mismatches++;
					end
					if (m_axis_tdata[67:64] !== w.nchars) begin
						$error("chunk_chars: expected %0d, got %0d", w.nchars,
							m_axis_tdata[67:64]);
						mismatches++;
					end
					if (m_axis_tlast !== w.last) begin
						$error("last_chunk: expected %0b, got %0b", w.last, m_axis_tlast);
						mismatches++;
					end
				end
			end
			// one long hold early on so the block backs up into its input
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && words_seen >= 40) begin
				hold_done = 1'b1;
				hold_left = 400;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 7);
			end else begin
				nxt_ready = 1'b1;
			end
		end else begin
			stall_left = 0;
		end
		m_axis_tready <= nxt_ready;
	end

	initial begin
		logic [127:0] v;
		logic [127:0] all_ones;
		int           nb;
		all_ones = '1;
		add_value('0, FMT_HEX);
		add_value('0, FMT_DEC);
		add_value('0, FMT_BIN);
		add_value('0, FMT_BIN3);
		add_value(all_ones, FMT_HEX);
		add_value(all_ones, FMT_DEC);
		add_value(all_ones, FMT_BIN);
		add_value(all_ones, FMT_BIN3);
		add_value(128'd1, FMT_HEX);
		add_value(128'd1, FMT_DEC);
		// hex text filling exactly one word, then one past it
		add_value(128'habcdef, FMT_HEX);
		add_value(128'habcdef1, FMT_HEX);
		add_value(128'd99999999, FMT_DEC);
		add_value(128'd100000000, FMT_DEC);
		add_value(128'd100000000000000000000000000000000000000, FMT_DEC);
		add_value(128'd99999999999999999999999999999999999999, FMT_DEC);
		add_value({1'b1, 127'd0}, FMT_BIN);
		add_value(128'hff, FMT_BIN);
		add_value(128'b101010, FMT_BIN);
		add_value(128'h0123456789abcdeffedcba9876543210, FMT_HEX);
		add_value({64'd1, 64'd0}, FMT_DEC);
		add_value(128'd5, FMT_BIN3);
		add_value({64'hdeadbeef00000000, 64'd0}, FMT_HEX);
		for (int n = 0; n < 300; n++) begin
			v = {$urandom, $urandom, $urandom, $urandom};
			nb = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(0, 128);
			if (nb < 128) begin
				v &= (128'd1 << nb) - 128'd1;
			end
			add_value(v, fmt_e'($urandom_range(0, 3)));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (value_queue.size() != 0 || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
